@@ hdl/mke_pkg.sv @@
// mke_pkg: shared types and constants of the mouse keys emulator
// item and result payload structs, key codes, report codes, register indexes
// no dependencies
`timescale 1ns / 1ps

package mke_pkg;

  // one input item
  typedef struct packed {
    logic        kind;
    logic [5:0]  key_code;
    logic        key_down;
    logic        is_repeat;
    logic [15:0] event_tag;
    logic [1:0]  physical_kind;
  } item_t;

  // one result item
  typedef struct packed {
    logic               handled;
    logic [1:0]         report;
    logic [15:0]        buttons;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic [15:0]        report_tag;
    logic [1:0]         report_physical;
  } result_t;

  // configuration registers as seen by the core
  typedef struct packed {
    logic [15:0] initial_wait_pointer;
    logic [15:0] repeat_wait_pointer;
    logic [15:0] initial_wait_scroll;
    logic [15:0] repeat_wait_scroll;
    logic [9:0]  max_speed_pointer;
    logic [9:0]  accel_pointer;
    logic [9:0]  max_speed_scroll;
    logic [9:0]  accel_scroll;
  } cfg_t;

  // item kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // report codes
  localparam logic [1:0] REPORT_NONE    = 2'd0;
  localparam logic [1:0] REPORT_POINTER = 2'd1;
  localparam logic [1:0] REPORT_SCROLL  = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_INITIAL_WAIT_POINTER = 3'd0;
  localparam logic [2:0] CFG_REPEAT_WAIT_POINTER  = 3'd1;
  localparam logic [2:0] CFG_INITIAL_WAIT_SCROLL  = 3'd2;
  localparam logic [2:0] CFG_REPEAT_WAIT_SCROLL   = 3'd3;
  localparam logic [2:0] CFG_MAX_SPEED_POINTER    = 3'd4;
  localparam logic [2:0] CFG_ACCEL_POINTER        = 3'd5;
  localparam logic [2:0] CFG_MAX_SPEED_SCROLL     = 3'd6;
  localparam logic [2:0] CFG_ACCEL_SCROLL         = 3'd7;

  // register reset values
  localparam logic [15:0] RST_INITIAL_WAIT_POINTER = 16'd0;
  localparam logic [15:0] RST_REPEAT_WAIT_POINTER  = 16'd20;
  localparam logic [15:0] RST_INITIAL_WAIT_SCROLL  = 16'd0;
  localparam logic [15:0] RST_REPEAT_WAIT_SCROLL   = 16'd50;
  localparam logic [9:0]  RST_MAX_SPEED_POINTER    = 10'd10;
  localparam logic [9:0]  RST_ACCEL_POINTER        = 10'd1;
  localparam logic [9:0]  RST_MAX_SPEED_SCROLL     = 10'd10;
  localparam logic [9:0]  RST_ACCEL_SCROLL         = 10'd1;

  // key codes
  localparam logic [5:0] KEY_BTN_FIRST   = 6'd1;
  localparam logic [5:0] KEY_BTN_LAST    = 6'd16;
  localparam logic [5:0] KEY_LOCK_FIRST  = 6'd17;
  localparam logic [5:0] KEY_LOCK_LAST   = 6'd32;
  localparam logic [5:0] KEY_UNLOCK_ALL  = 6'd33;
  localparam logic [5:0] KEY_UP          = 6'd34;
  localparam logic [5:0] KEY_DOWN        = 6'd35;
  localparam logic [5:0] KEY_LEFT        = 6'd36;
  localparam logic [5:0] KEY_RIGHT       = 6'd37;
  localparam logic [5:0] KEY_NE          = 6'd38;
  localparam logic [5:0] KEY_NW          = 6'd39;
  localparam logic [5:0] KEY_SE          = 6'd40;
  localparam logic [5:0] KEY_SW          = 6'd41;
  localparam logic [5:0] KEY_SCROLL_UP    = 6'd42;
  localparam logic [5:0] KEY_SCROLL_DOWN  = 6'd43;
  localparam logic [5:0] KEY_SCROLL_LEFT  = 6'd44;
  localparam logic [5:0] KEY_SCROLL_RIGHT = 6'd45;
  localparam logic [5:0] KEY_HIGH_SPEED  = 6'd46;
  localparam logic [5:0] KEY_FIX_UP      = 6'd47;
  localparam logic [5:0] KEY_FIX_DOWN    = 6'd48;
  localparam logic [5:0] KEY_FIX_LEFT    = 6'd49;
  localparam logic [5:0] KEY_FIX_RIGHT   = 6'd50;

  // motion constants
  localparam logic [10:0] HIGH_SPEED_POINTER = 11'd40;
  localparam logic [10:0] HIGH_SPEED_SCROLL  = 11'd40;
  localparam logic [14:0] FIXED_STEP         = 15'd100;
  localparam logic [4:0]  WHEEL_DELTA_SCALE  = 5'd1;
  localparam logic        SCROLL_INVERT      = 1'b0;
  localparam logic [10:0] SCALE_MAX          = 11'd2047;
  localparam logic [7:0]  COUNT_MAX          = 8'd255;

endpackage

@@ hdl/mke_cfg_regs.sv @@
// mke_cfg_regs: configuration register file of the mouse keys emulator
// depends on mke_pkg for the register struct, indexes and reset values
`timescale 1ns / 1ps

module mke_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [15:0]   wr_data,
  output mke_pkg::cfg_t regs
);

  // register writes, one per request
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.initial_wait_pointer <= mke_pkg::RST_INITIAL_WAIT_POINTER;
      regs.repeat_wait_pointer  <= mke_pkg::RST_REPEAT_WAIT_POINTER;
      regs.initial_wait_scroll  <= mke_pkg::RST_INITIAL_WAIT_SCROLL;
      regs.repeat_wait_scroll   <= mke_pkg::RST_REPEAT_WAIT_SCROLL;
      regs.max_speed_pointer    <= mke_pkg::RST_MAX_SPEED_POINTER;
      regs.accel_pointer        <= mke_pkg::RST_ACCEL_POINTER;
      regs.max_speed_scroll     <= mke_pkg::RST_MAX_SPEED_SCROLL;
      regs.accel_scroll         <= mke_pkg::RST_ACCEL_SCROLL;
    end else if (wr_en) begin
      case (wr_index)
        mke_pkg::CFG_INITIAL_WAIT_POINTER: regs.initial_wait_pointer <= wr_data;
        mke_pkg::CFG_REPEAT_WAIT_POINTER:  regs.repeat_wait_pointer  <= wr_data;
        mke_pkg::CFG_INITIAL_WAIT_SCROLL:  regs.initial_wait_scroll  <= wr_data;
        mke_pkg::CFG_REPEAT_WAIT_SCROLL:   regs.repeat_wait_scroll   <= wr_data;
        mke_pkg::CFG_MAX_SPEED_POINTER:    regs.max_speed_pointer    <= wr_data[9:0];
        mke_pkg::CFG_ACCEL_POINTER:        regs.accel_pointer        <= wr_data[9:0];
        mke_pkg::CFG_MAX_SPEED_SCROLL:     regs.max_speed_scroll     <= wr_data[9:0];
        mke_pkg::CFG_ACCEL_SCROLL:         regs.accel_scroll         <= wr_data[9:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/mke_core.sv @@
// mke_core: state and single-pass update logic of the mouse keys emulator
// holds press counts, locks, direction, scale and countdown; depends on mke_pkg
`timescale 1ns / 1ps

module mke_core #(
  parameter int NUM_BUTTONS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mke_pkg::item_t   item,
  input  mke_pkg::cfg_t    cfg,
  output logic             res_valid,
  output mke_pkg::result_t res
);

  localparam int BTN_IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // state
  logic signed [1:0]      dir_x, dir_y;
  logic [10:0]            speed_scale;
  logic                   scroll_mode, high_speed;
  logic [15:0]            saved_tag;
  logic [1:0]             saved_physical;
  logic [15:0]            countdown;
  logic                   timer_armed;
  logic [7:0]             press_count [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] lock_bits;

  logic signed [1:0]      dir_x_next, dir_y_next;
  logic [10:0]            speed_scale_next;
  logic                   scroll_mode_next, high_speed_next;
  logic [15:0]            saved_tag_next;
  logic [1:0]             saved_physical_next;
  logic [15:0]            countdown_next;
  logic                   timer_armed_next;
  logic [7:0]             press_count_next [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] lock_bits_next;

  // clamp a direction sum to -1..1
  function automatic logic signed [1:0] clamp1(input logic signed [2:0] v);
    if (v > 3'sd1) begin
      return 2'sd1;
    end else if (v < -3'sd1) begin
      return -2'sd1;
    end
    return v[1:0];
  endfunction

  // signed displacement from a direction and a magnitude
  function automatic logic signed [17:0] apply_dir(input logic signed [1:0] d,
                                                   input logic [15:0] mag);
    logic signed [17:0] m;
    m = signed'({2'b00, mag});
    case (d)
      2'sd1:   return m;
      -2'sd1:  return -m;
      default: return 18'sd0;
    endcase
  endfunction

  // saturate to 16 bits signed
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  logic [5:0]              code;
  logic [5:0]              btn_raw, lock_raw;
  logic [BTN_IDX_W-1:0]    btn_idx, lock_idx;
  logic signed [1:0]       ddx, ddy;
  logic [10:0]             scale_used;
  logic [15:0]             mag;
  logic signed [17:0]      mx, my;
  logic [9:0]              max_sp, acc;
  logic [11:0]             scale_sum;
  logic [1:0]              report;
  logic                    handled;
  logic [15:0]             mask;

  assign code     = item.key_code;
  assign btn_raw  = code - mke_pkg::KEY_BTN_FIRST;
  assign lock_raw = code - mke_pkg::KEY_LOCK_FIRST;
  assign btn_idx  = btn_raw[BTN_IDX_W-1:0];
  assign lock_idx = lock_raw[BTN_IDX_W-1:0];

  // direction deltas of the motion and scroll keys
  always_comb begin
    ddx = 2'sd0;
    ddy = 2'sd0;
    case (code)
      mke_pkg::KEY_UP, mke_pkg::KEY_SCROLL_UP:       ddy = -2'sd1;
      mke_pkg::KEY_DOWN, mke_pkg::KEY_SCROLL_DOWN:   ddy = 2'sd1;
      mke_pkg::KEY_LEFT, mke_pkg::KEY_SCROLL_LEFT:   ddx = -2'sd1;
      mke_pkg::KEY_RIGHT, mke_pkg::KEY_SCROLL_RIGHT: ddx = 2'sd1;
      mke_pkg::KEY_NE: begin
        ddx = 2'sd1;
        ddy = -2'sd1;
      end
      mke_pkg::KEY_NW: begin
        ddx = -2'sd1;
        ddy = -2'sd1;
      end
      mke_pkg::KEY_SE: begin
        ddx = 2'sd1;
        ddy = 2'sd1;
      end
      mke_pkg::KEY_SW: begin
        ddx = -2'sd1;
        ddy = 2'sd1;
      end
      default: begin
      end
    endcase
  end

  // update of the state and the result for one item
  always_comb begin
    dir_x_next          = dir_x;
    dir_y_next          = dir_y;
    speed_scale_next    = speed_scale;
    scroll_mode_next    = scroll_mode;
    high_speed_next     = high_speed;
    saved_tag_next      = saved_tag;
    saved_physical_next = saved_physical;
    countdown_next      = countdown;
    timer_armed_next    = timer_armed;
    press_count_next    = press_count;
    lock_bits_next      = lock_bits;
    res_valid           = 1'b0;
    handled             = 1'b0;
    report              = mke_pkg::REPORT_NONE;
    mx                  = 18'sd0;
    my                  = 18'sd0;
    scale_used          = speed_scale;
    mag                 = 16'd0;
    max_sp              = cfg.max_speed_pointer;
    acc                 = cfg.accel_pointer;
    scale_sum           = 12'd0;

    if (item.kind == mke_pkg::KIND_TICK) begin
      // countdown and repeated motion
      if (timer_armed) begin
        if (countdown > 16'd1) begin
          countdown_next = countdown - 16'd1;
        end else begin
          res_valid = 1'b1;
          if (!scroll_mode) begin
            report         = mke_pkg::REPORT_POINTER;
            scale_used     = high_speed ? mke_pkg::HIGH_SPEED_POINTER : speed_scale;
            mag            = 16'(scale_used);
            max_sp         = cfg.max_speed_pointer;
            acc            = cfg.accel_pointer;
            countdown_next = cfg.repeat_wait_pointer;
            mx             = apply_dir(dir_x, mag);
            my             = apply_dir(dir_y, mag);
          end else begin
            report         = mke_pkg::REPORT_SCROLL;
            scale_used     = high_speed ? mke_pkg::HIGH_SPEED_SCROLL : speed_scale;
            mag            = 16'(scale_used) * 16'(mke_pkg::WHEEL_DELTA_SCALE);
            max_sp         = cfg.max_speed_scroll;
            acc            = cfg.accel_scroll;
            countdown_next = cfg.repeat_wait_scroll;
            mx             = apply_dir(dir_x, mag);
            my             = apply_dir(dir_y, mag);
            if (mke_pkg::SCROLL_INVERT) begin
              mx = -mx;
              my = -my;
            end
          end
          // acceleration while the scale is below the maximum
          if (speed_scale < {1'b0, max_sp}) begin
            scale_sum = {1'b0, speed_scale} + {2'b00, acc};
            speed_scale_next = (scale_sum > {1'b0, mke_pkg::SCALE_MAX}) ?
                               mke_pkg::SCALE_MAX : scale_sum[10:0];
          end
        end
      end
    end else begin
      res_valid           = 1'b1;
      saved_physical_next = item.physical_kind;
      if (code inside {[mke_pkg::KEY_BTN_FIRST:mke_pkg::KEY_BTN_LAST]}) begin
        // held buttons
        if (btn_raw < 6'(NUM_BUTTONS)) begin
          handled = 1'b1;
          if (!item.is_repeat) begin
            if (item.key_down) begin
              if (press_count[btn_idx] < mke_pkg::COUNT_MAX) begin
                press_count_next[btn_idx] = press_count[btn_idx] + 8'd1;
              end
            end else if (press_count[btn_idx] != 8'd0) begin
              press_count_next[btn_idx] = press_count[btn_idx] - 8'd1;
            end
            report = mke_pkg::REPORT_POINTER;
          end
        end
      end else if (code inside {[mke_pkg::KEY_UP:mke_pkg::KEY_HIGH_SPEED]}) begin
        // direction, scroll and high speed keys
        handled = 1'b1;
        if (!item.is_repeat) begin
          if (code == mke_pkg::KEY_HIGH_SPEED) begin
            high_speed_next = item.key_down;
          end else if (item.key_down) begin
            dir_x_next       = clamp1(3'(dir_x) + 3'(ddx));
            dir_y_next       = clamp1(3'(dir_y) + 3'(ddy));
            scroll_mode_next = (code >= mke_pkg::KEY_SCROLL_UP);
          end else begin
            dir_x_next = clamp1(3'(dir_x) - 3'(ddx));
            dir_y_next = clamp1(3'(dir_y) - 3'(ddy));
          end
          saved_tag_next = item.event_tag;
          if (dir_x_next != 2'sd0 || dir_y_next != 2'sd0) begin
            countdown_next   = scroll_mode_next ? cfg.initial_wait_scroll
                                                : cfg.initial_wait_pointer;
            timer_armed_next = 1'b1;
          end else begin
            speed_scale_next = 11'd1;
            timer_armed_next = 1'b0;
          end
        end
      end else if (code inside {[mke_pkg::KEY_FIX_UP:mke_pkg::KEY_FIX_RIGHT]}) begin
        // fixed single steps
        handled = 1'b1;
        if (item.key_down) begin
          report = mke_pkg::REPORT_POINTER;
          case (code)
            mke_pkg::KEY_FIX_UP:   my = -18'(signed'({1'b0, mke_pkg::FIXED_STEP}));
            mke_pkg::KEY_FIX_DOWN: my = 18'(signed'({1'b0, mke_pkg::FIXED_STEP}));
            mke_pkg::KEY_FIX_LEFT: mx = -18'(signed'({1'b0, mke_pkg::FIXED_STEP}));
            default:               mx = 18'(signed'({1'b0, mke_pkg::FIXED_STEP}));
          endcase
        end
      end else if (code == mke_pkg::KEY_UNLOCK_ALL) begin
        handled        = 1'b1;
        lock_bits_next = '0;
        report         = mke_pkg::REPORT_POINTER;
      end else if (code inside {[mke_pkg::KEY_LOCK_FIRST:mke_pkg::KEY_LOCK_LAST]}) begin
        // lock toggles on press only
        if (lock_raw < 6'(NUM_BUTTONS)) begin
          handled = 1'b1;
          if (!item.is_repeat && item.key_down) begin
            lock_bits_next[lock_idx] = ~lock_bits[lock_idx];
            report = mke_pkg::REPORT_POINTER;
          end
        end
      end
    end
  end

  // button mask after the update
  always_comb begin
    mask = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      mask[i] = (press_count_next[i] != 8'd0) || lock_bits_next[i];
    end
  end

  // result fields, all but handled and report zero when nothing is reported
  always_comb begin
    res         = '0;
    res.handled = handled;
    res.report  = report;
    if (report != mke_pkg::REPORT_NONE) begin
      res.buttons = mask;
      res.move_x  = sat16(mx);
      res.move_y  = sat16(my);
      if (item.kind == mke_pkg::KIND_TICK) begin
        res.report_tag      = saved_tag;
        res.report_physical = saved_physical;
      end else begin
        res.report_tag      = item.event_tag;
        res.report_physical = item.physical_kind;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x          <= 2'sd0;
      dir_y          <= 2'sd0;
      speed_scale    <= 11'd1;
      scroll_mode    <= 1'b0;
      high_speed     <= 1'b0;
      saved_tag      <= 16'd0;
      saved_physical <= 2'd0;
      countdown      <= 16'd0;
      timer_armed    <= 1'b0;
      lock_bits      <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_count[i] <= 8'd0;
      end
    end else if (step) begin
      dir_x          <= dir_x_next;
      dir_y          <= dir_y_next;
      speed_scale    <= speed_scale_next;
      scroll_mode    <= scroll_mode_next;
      high_speed     <= high_speed_next;
      saved_tag      <= saved_tag_next;
      saved_physical <= saved_physical_next;
      countdown      <= countdown_next;
      timer_armed    <= timer_armed_next;
      lock_bits      <= lock_bits_next;
      press_count    <= press_count_next;
    end
  end

  // timer only runs while some direction is held
  a_armed_has_dir: assert property (@(posedge clk) disable iff (rst)
    timer_armed |-> (dir_x != 2'sd0 || dir_y != 2'sd0))
    else $error("timer armed with no direction");

  // clamped directions never take the unused code
  a_dir_clamped: assert property (@(posedge clk) disable iff (rst)
    dir_x != -2'sd2 && dir_y != -2'sd2)
    else $error("direction outside -1..1");

  // scale never drops to zero
  a_scale_nonzero: assert property (@(posedge clk) disable iff (rst)
    speed_scale != 11'd0)
    else $error("speed scale is zero");

  // scroll reports come only from an expiring countdown
  a_scroll_from_tick: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.report == mke_pkg::REPORT_SCROLL) |->
      (item.kind == mke_pkg::KIND_TICK && !res.handled))
    else $error("scroll report not from a tick");

  // disarming the timer resets the scale
  a_disarm_scale: assert property (@(posedge clk) disable iff (rst)
    $fell(timer_armed) |-> speed_scale == 11'd1)
    else $error("scale kept after disarm");

endmodule

@@ hdl/mouse_keys_emulator.sv @@
// A request accepted into the input register has its result loaded into the result
// register once that register is free, and the result is valid from then on. A tick
// that does not expire gives no result. Throughput: one item per cycle; the input
// register advances whenever the result register is empty or is being taken, so only
// a stalled result slows the input. Reset (rst, synchronous): direction, scale 1,
// modes, countdown, press counts, locks and configuration registers return to their
// reset values.
`timescale 1ns / 1ps

module mouse_keys_emulator #(
  parameter int NUM_BUTTONS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  mke_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output mke_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  logic             s1_valid;
  mke_pkg::item_t   s1_item;
  logic             out_free;
  logic             s1_adv;
  logic             item_accept;
  mke_pkg::cfg_t    cfg;
  logic             core_res_valid;
  mke_pkg::result_t core_res;

  // handshake control
  assign out_free    = !result_valid || !result_stall;
  assign s1_adv      = s1_valid && out_free;
  assign item_stall  = s1_valid && !out_free;
  assign item_accept = item_valid && !item_stall;
  assign cfg_ready   = 1'b1;

  // configuration registers
  mke_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_item <= item;
    end
  end

  // state update and result logic
  mke_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .item      (s1_item),
    .cfg       (cfg),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_adv && core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && core_res_valid) begin
      result <= core_res;
    end
  end

  // a stall on the input only comes from a blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid && result_stall))
    else $error("input stalled without a blocked result");

  // a request that advances with a result shows up in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && core_res_valid) |=> result_valid)
    else $error("result lost");

  // a held input request is not dropped
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid)
    else $error("input request dropped while blocked");

endmodule
